// ----- src/tcs_pkg.sv -----
// Shared constants, types and helpers for the text console with scrollback.
package tcs_pkg;

    localparam int COLS       = 80;
    localparam int ROWS       = 25;
    localparam int HIST_LINES = 256;
    localparam int CELLS      = COLS * ROWS;
    localparam int HIST_CELLS = HIST_LINES * COLS;
    localparam int CAP        = HIST_LINES - ROWS;

    localparam int COL_W   = $clog2(COLS);
    localparam int ROW_W   = $clog2(ROWS);
    localparam int CELL_W  = $clog2(CELLS);
    localparam int SLOT_W  = $clog2(HIST_LINES);
    localparam int HADDR_W = $clog2(HIST_CELLS);
    localparam int OFF_W   = 8;
    localparam int LW_W    = 32;
    localparam int LINE_W  = LW_W + 2;
    localparam int DELTA_W = 11;

    localparam logic [7:0]  NEWLINE_CHAR   = 8'd10;
    localparam logic [7:0]  BACKSPACE_CHAR = 8'd8;
    localparam logic [7:0]  BLANK_CHAR     = 8'h20;
    localparam logic [7:0]  RESET_COLOR    = 8'h0F;
    localparam logic [15:0] RESET_CELL     = {RESET_COLOR, BLANK_CHAR};

    typedef enum logic [1:0] {
        K_WRITE  = 2'd0,
        K_SCROLL = 2'd1,
        K_READ   = 2'd2,
        K_NOP    = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        C_PRINT,
        C_NEWLINE,
        C_BACK
    } t_cls;

    typedef enum logic [1:0] {
        SRC_CONST,
        SRC_HIST,
        SRC_SCREEN
    } t_src;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_RINIT,
        ST_REDRAW,
        ST_HIST,
        ST_SCREEN,
        ST_SHIFT,
        ST_READ,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_kind                      kind;
        t_cls                       cls;
        logic [7:0]                 ch;
        logic [7:0]                 color;
        logic signed [DELTA_W-1:0]  delta;
        logic [CELL_W-1:0]          idx;
    } t_cmd;

    typedef struct packed {
        logic [15:0]        value;
        logic [OFF_W-1:0]   offset;
        logic [CELL_W-1:0]  cursor;
    } t_res;

    function automatic logic [15:0] blank_cell(input logic [7:0] color);
        return {color, BLANK_CHAR};
    endfunction

endpackage

// ----- src/tcs_front.sv -----
// Input stage: accept beats, classify them and hold them in a two-entry queue.
module tcs_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [39:0]         i_s_tdata,
    input  logic [1:0]          i_s_tuser,
    output logic                o_cmd_valid,
    input  logic                i_cmd_pop,
    output tcs_pkg::t_cmd       o_cmd
);
    import tcs_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_cmd       w_cmd;
    logic       w_push;
    logic       w_pop;

    always_comb begin
        w_cmd.kind  = t_kind'(i_s_tuser);
        w_cmd.ch    = i_s_tdata[7:0];
        w_cmd.color = i_s_tdata[15:8];
        w_cmd.delta = $signed(i_s_tdata[26:16]);
        w_cmd.idx   = i_s_tdata[37:27];
        if (i_s_tdata[7:0] == NEWLINE_CHAR) begin
            w_cmd.cls = C_NEWLINE;
        end else if (i_s_tdata[7:0] == BACKSPACE_CHAR) begin
            w_cmd.cls = C_BACK;
        end else begin
            w_cmd.cls = C_PRINT;
        end
    end

    assign o_s_tready  = (r_cnt != 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_push      = i_s_tvalid && o_s_tready;
    assign w_pop       = i_cmd_pop && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

endmodule

// ----- src/tcs_back.sv -----
// Execution stage: sequencer over the screen and history memories.
module tcs_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    output logic            o_cmd_pop,
    input  tcs_pkg::t_cmd   i_cmd,
    output logic            o_res_valid,
    input  logic            i_res_ready,
    output tcs_pkg::t_res   o_res
);
    import tcs_pkg::*;

    logic [15:0] r_screen [CELLS];
    logic [15:0] r_hist   [HIST_CELLS];

    t_state              r_state, n_state;
    t_cmd                r_cmd;
    logic [ROW_W-1:0]    r_crow;
    logic [COL_W-1:0]    r_ccol;
    logic [COL_W-1:0]    r_hcol;
    logic [LW_W-1:0]     r_lw;
    logic [OFF_W-1:0]    r_scroll;
    logic [7:0]          r_color;
    logic [ROW_W-1:0]    r_row;
    logic [COL_W-1:0]    r_col;
    logic [LINE_W-1:0]   r_line;
    logic [CELL_W-1:0]   r_sh;
    logic [HADDR_W-1:0]  r_clr;
    logic [15:0]         r_val;
    logic                r_out_valid;
    t_res                r_res;

    logic [15:0]         r_hist_q, r_scr_q;
    logic                r_pw_valid, n_pw_valid;
    logic [CELL_W-1:0]   r_pw_addr, n_pw_addr;
    t_src                r_pw_src, n_pw_src;
    logic [15:0]         r_pw_data, n_pw_data;

    logic                w_hw_en;
    logic [HADDR_W-1:0]  w_hw_addr;
    logic [15:0]         w_hw_data;
    logic                w_hist_re;
    logic [HADDR_W-1:0]  w_hist_raddr;
    logic                w_scr_re;
    logic [CELL_W-1:0]   w_scr_raddr;

    logic [CELL_W-1:0]   w_cur_cell;
    logic [HADDR_W-1:0]  w_hbase;
    logic [HADDR_W-1:0]  w_red_haddr;
    logic [CELL_W-1:0]   w_red_saddr;
    logic                w_red_last;
    logic                w_shift;
    logic [OFF_W-1:0]    w_lim;
    logic signed [12:0]  w_sum;
    logic [OFF_W-1:0]    w_off;
    logic [LW_W-1:0]     w_lw_inc;
    logic [ROW_W-1:0]    w_live_row;

    assign w_cur_cell  = CELL_W'(r_crow) * CELL_W'(COLS) + CELL_W'(r_ccol);
    assign w_hbase     = HADDR_W'(r_lw[SLOT_W-1:0]) * HADDR_W'(COLS);
    assign w_red_haddr = HADDR_W'(r_line[SLOT_W-1:0]) * HADDR_W'(COLS) + HADDR_W'(r_col);
    assign w_red_saddr = CELL_W'(r_row) * CELL_W'(COLS) + CELL_W'(r_col);
    assign w_red_last  = (r_row == ROW_W'(ROWS - 1)) && (r_col == COL_W'(COLS - 1));
    assign w_lw_inc    = (r_lw == '1) ? r_lw : r_lw + LW_W'(1);

    always_comb begin
        w_shift = 1'b0;
        unique case (r_cmd.cls)
            C_PRINT:   w_shift = (r_crow == ROW_W'(ROWS - 1)) && (r_ccol == COL_W'(COLS - 1));
            C_NEWLINE: w_shift = (r_crow == ROW_W'(ROWS - 1));
            default:   w_shift = 1'b0;
        endcase
    end

    always_comb begin
        if (r_lw >= LW_W'(ROWS - 1 + CAP)) begin
            w_lim = OFF_W'(CAP);
        end else if (r_lw >= LW_W'(ROWS - 1)) begin
            w_lim = OFF_W'(r_lw - LW_W'(ROWS - 1));
        end else begin
            w_lim = '0;
        end
        w_sum = $signed({5'b0, r_scroll}) + 13'(r_cmd.delta);
        if (w_sum < 0) begin
            w_off = '0;
        end else if (w_sum > $signed({5'b0, w_lim})) begin
            w_off = w_lim;
        end else begin
            w_off = w_sum[OFF_W-1:0];
        end
        if (r_lw == '0) begin
            w_live_row = '0;
        end else if (r_lw < LW_W'(ROWS)) begin
            w_live_row = r_lw[ROW_W-1:0];
        end else begin
            w_live_row = ROW_W'(ROWS - 1);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr == HADDR_W'(HIST_CELLS - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_cmd_valid && !r_out_valid) n_state = ST_START;
            end
            ST_START: begin
                unique case (r_cmd.kind)
                    K_WRITE:  n_state = (r_scroll != '0) ? ST_RINIT : ST_HIST;
                    K_SCROLL: n_state = ST_RINIT;
                    K_READ:   n_state = (r_cmd.idx < CELL_W'(CELLS)) ? ST_READ : ST_DONE;
                    default:  n_state = ST_DONE;
                endcase
            end
            ST_RINIT:  n_state = ST_REDRAW;
            ST_REDRAW: begin
                if (w_red_last) n_state = (r_cmd.kind == K_WRITE) ? ST_HIST : ST_DONE;
            end
            ST_HIST: begin
                if (r_cmd.cls != C_NEWLINE || r_col == COL_W'(COLS - 1)) n_state = ST_SCREEN;
            end
            ST_SCREEN: n_state = w_shift ? ST_SHIFT : ST_DONE;
            ST_SHIFT: begin
                if (r_sh == CELL_W'(CELLS - 1)) n_state = ST_DONE;
            end
            ST_READ:   n_state = ST_DONE;
            ST_DONE:   n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_hw_en      = 1'b0;
        w_hw_addr    = '0;
        w_hw_data    = '0;
        w_hist_re    = 1'b0;
        w_hist_raddr = '0;
        w_scr_re     = 1'b0;
        w_scr_raddr  = '0;
        n_pw_valid   = 1'b0;
        n_pw_addr    = '0;
        n_pw_src     = SRC_CONST;
        n_pw_data    = '0;
        o_cmd_pop    = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                w_hw_en    = 1'b1;
                w_hw_addr  = r_clr;
                w_hw_data  = RESET_CELL;
                n_pw_valid = (r_clr < HADDR_W'(CELLS));
                n_pw_addr  = r_clr[CELL_W-1:0];
                n_pw_data  = RESET_CELL;
            end
            ST_IDLE: begin
                o_cmd_pop = i_cmd_valid && !r_out_valid;
            end
            ST_START: begin
                w_scr_re    = (r_cmd.kind == K_READ) && (r_cmd.idx < CELL_W'(CELLS));
                w_scr_raddr = r_cmd.idx;
            end
            ST_REDRAW: begin
                w_hist_re    = 1'b1;
                w_hist_raddr = w_red_haddr;
                n_pw_valid   = 1'b1;
                n_pw_addr    = w_red_saddr;
                n_pw_src     = r_line[LINE_W-1] ? SRC_CONST : SRC_HIST;
                n_pw_data    = blank_cell(r_color);
            end
            ST_HIST: begin
                unique case (r_cmd.cls)
                    C_PRINT: begin
                        w_hw_en   = 1'b1;
                        w_hw_addr = w_hbase + HADDR_W'(r_hcol);
                        w_hw_data = {r_cmd.color, r_cmd.ch};
                    end
                    C_BACK: begin
                        w_hw_en   = (r_hcol != '0);
                        w_hw_addr = w_hbase + HADDR_W'(r_hcol) - HADDR_W'(1);
                        w_hw_data = blank_cell(r_cmd.color);
                    end
                    default: begin
                        w_hw_en   = 1'b1;
                        w_hw_addr = w_hbase + HADDR_W'(r_col);
                        w_hw_data = blank_cell(r_cmd.color);
                    end
                endcase
            end
            ST_SCREEN: begin
                unique case (r_cmd.cls)
                    C_PRINT: begin
                        n_pw_valid = 1'b1;
                        n_pw_addr  = w_cur_cell;
                        n_pw_data  = {r_cmd.color, r_cmd.ch};
                    end
                    C_BACK: begin
                        n_pw_valid = (w_cur_cell != '0);
                        n_pw_addr  = w_cur_cell - CELL_W'(1);
                        n_pw_data  = blank_cell(r_cmd.color);
                    end
                    default: begin
                        n_pw_valid = 1'b0;
                    end
                endcase
            end
            ST_SHIFT: begin
                n_pw_valid = 1'b1;
                n_pw_addr  = r_sh;
                n_pw_data  = blank_cell(r_cmd.color);
                if (r_sh < CELL_W'(CELLS - COLS)) begin
                    w_scr_re    = 1'b1;
                    w_scr_raddr = r_sh + CELL_W'(COLS);
                    n_pw_src    = SRC_SCREEN;
                end
            end
            default: begin
                n_pw_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_hw_en) begin
            r_hist[w_hw_addr] <= w_hw_data;
        end
        if (w_hist_re) begin
            r_hist_q <= r_hist[w_hist_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pw_valid) begin
            case (r_pw_src)
                SRC_HIST:   r_screen[r_pw_addr] <= r_hist_q;
                SRC_SCREEN: r_screen[r_pw_addr] <= r_scr_q;
                default:    r_screen[r_pw_addr] <= r_pw_data;
            endcase
        end
        if (w_scr_re) begin
            r_scr_q <= r_screen[w_scr_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_pw_addr <= n_pw_addr;
        r_pw_src  <= n_pw_src;
        r_pw_data <= n_pw_data;
        if (!i_rst_n) begin
            r_pw_valid <= 1'b0;
        end else begin
            r_pw_valid <= n_pw_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_crow      <= '0;
            r_ccol      <= '0;
            r_hcol      <= '0;
            r_lw        <= '0;
            r_scroll    <= '0;
            r_color     <= RESET_COLOR;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_out_valid && i_res_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + HADDR_W'(1);
                end
                ST_IDLE: begin
                    if (o_cmd_pop) begin
                        r_cmd <= i_cmd;
                        r_val <= '0;
                    end
                end
                ST_START: begin
                    if (r_cmd.kind == K_WRITE) begin
                        r_color  <= r_cmd.color;
                        r_scroll <= '0;
                        r_col    <= r_hcol;
                    end else if (r_cmd.kind == K_SCROLL) begin
                        r_scroll <= w_off;
                    end
                end
                ST_RINIT: begin
                    r_line <= LINE_W'(r_lw) - LINE_W'(ROWS - 1) - LINE_W'(r_scroll);
                    r_row  <= '0;
                    r_col  <= '0;
                end
                ST_REDRAW: begin
                    if (r_col == COL_W'(COLS - 1)) begin
                        r_col  <= '0;
                        r_row  <= r_row + ROW_W'(1);
                        r_line <= r_line + LINE_W'(1);
                    end else begin
                        r_col <= r_col + COL_W'(1);
                    end
                    if (w_red_last) begin
                        r_crow <= (r_scroll == '0) ? w_live_row : ROW_W'(ROWS - 1);
                        r_ccol <= r_hcol;
                        r_col  <= r_hcol;
                    end
                end
                ST_HIST: begin
                    unique case (r_cmd.cls)
                        C_PRINT: begin
                            if (r_hcol == COL_W'(COLS - 1)) begin
                                r_hcol <= '0;
                                r_lw   <= w_lw_inc;
                            end else begin
                                r_hcol <= r_hcol + COL_W'(1);
                            end
                        end
                        C_BACK: begin
                            if (r_hcol != '0) r_hcol <= r_hcol - COL_W'(1);
                        end
                        default: begin
                            if (r_col == COL_W'(COLS - 1)) begin
                                r_lw   <= w_lw_inc;
                                r_hcol <= '0;
                            end else begin
                                r_col <= r_col + COL_W'(1);
                            end
                        end
                    endcase
                end
                ST_SCREEN: begin
                    r_sh <= '0;
                    unique case (r_cmd.cls)
                        C_PRINT: begin
                            if (r_ccol == COL_W'(COLS - 1)) begin
                                r_ccol <= '0;
                                if (r_crow != ROW_W'(ROWS - 1)) r_crow <= r_crow + ROW_W'(1);
                            end else begin
                                r_ccol <= r_ccol + COL_W'(1);
                            end
                        end
                        C_BACK: begin
                            if (w_cur_cell != '0) begin
                                if (r_ccol == '0) begin
                                    r_crow <= r_crow - ROW_W'(1);
                                    r_ccol <= COL_W'(COLS - 1);
                                end else begin
                                    r_ccol <= r_ccol - COL_W'(1);
                                end
                            end
                        end
                        default: begin
                            r_ccol <= '0;
                            if (r_crow != ROW_W'(ROWS - 1)) r_crow <= r_crow + ROW_W'(1);
                        end
                    endcase
                end
                ST_SHIFT: begin
                    r_sh <= r_sh + CELL_W'(1);
                end
                ST_READ: begin
                    r_val <= r_scr_q;
                end
                ST_DONE: begin
                    r_out_valid   <= 1'b1;
                    r_res.cursor  <= w_cur_cell;
                    r_res.offset  <= r_scroll;
                    r_res.value   <= r_val;
                end
                default: begin
                    r_sh <= r_sh;
                end
            endcase
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_res;

endmodule

// ----- src/text_console_with_scrollback.sv -----
// Top level of the text console with scrollback history.
//
//  port group  dir  tdata fields (low bit up)                      tuser
//  s (in)      in   char_code 8, color 8, scroll_delta 11,         mode 2
//                   cell_index 11, 2 zero bits
//  m (out)     out  cursor_position 11, view_offset 8,             -
//                   cell_value 16, 5 zero bits
//
// A newline blanks the rest of its history line one cell at a time. A shift of the
// screen, and the redraw that a scroll or a write while scrolled adds, both move one
// cell per cycle on the screen memory port. After reset a clearing pass fills both
// memories with blank cells; beats queue in a two-entry input buffer.
module text_console_with_scrollback (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // char_code, color, scroll_delta, cell_index, pad
    input  logic [1:0]  i_s_tuser,   // mode
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata    // cursor_position, view_offset, cell_value, pad
);
    import tcs_pkg::*;

    logic   w_cmd_valid;
    logic   w_cmd_pop;
    t_cmd   w_cmd;
    t_res   w_res;

    tcs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_pop   (w_cmd_pop),
        .o_cmd       (w_cmd)
    );

    tcs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_pop   (w_cmd_pop),
        .i_cmd       (w_cmd),
        .o_res_valid (o_m_tvalid),
        .i_res_ready (i_m_tready),
        .o_res       (w_res)
    );

    assign o_m_tdata = {5'b0, w_res};

`ifndef SYNTHESIS
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[CELL_W-1:0] < CELL_W'(CELLS)))
        else $error("cursor outside screen");
    a_offset_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[CELL_W+OFF_W-1:CELL_W] <= OFF_W'(CAP)))
        else $error("scroll offset above cap");
    a_pop_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_pop |-> (w_cmd_valid && !o_m_tvalid))
        else $error("command taken while result pending");
`endif

endmodule

// ----- dv/tb_text_console_with_scrollback.sv -----
// Testbench for the text console with scrollback: random and directed beats checked against a model.
`timescale 1ns / 100ps

module tb_text_console_with_scrollback;
    import tcs_pkg::*;

    typedef struct {
        t_kind       kind;
        logic [7:0]  ch;
        logic [7:0]  color;
        logic [10:0] delta;
        logic [10:0] idx;
    } t_beat;

    class console_scoreboard;
        logic [15:0] screen [CELLS];
        logic [15:0] hist [HIST_CELLS];
        int unsigned cursor, hcol, scroll;
        logic [31:0] lines;
        logic [7:0]  last_color;
        t_res        pending [$];
        int          errors;

        function new();
            foreach (screen[i]) screen[i] = RESET_CELL;
            foreach (hist[i]) hist[i] = RESET_CELL;
            cursor = 0; hcol = 0; scroll = 0; lines = 0; last_color = RESET_COLOR;
            errors = 0;
        endfunction

        function void next_line();
            if (lines != 32'hFFFF_FFFF) lines++;
        endfunction

        function void redraw();
            longint first, line;
            int unsigned slot, r;
            first = longint'(lines) - (ROWS - 1) - scroll;
            for (int row = 0; row < ROWS; row++) begin
                line = first + row;
                slot = (line < 0) ? 0 : int'(line % HIST_LINES);
                for (int c = 0; c < COLS; c++)
                    screen[row * COLS + c] = (line < 0) ? blank_cell(last_color)
                                                       : hist[slot * COLS + c];
            end
            if (scroll == 0) begin
                r = (lines == 0) ? 0 : (lines < ROWS) ? int'(lines) : ROWS - 1;
                cursor = r * COLS + hcol;
            end else begin
                cursor = (ROWS - 1) * COLS + hcol;
            end
        endfunction

        function void shift_up(logic [7:0] color);
            for (int i = 0; i < (ROWS - 1) * COLS; i++) screen[i] = screen[i + COLS];
            for (int i = (ROWS - 1) * COLS; i < CELLS; i++) screen[i] = blank_cell(color);
            cursor = (ROWS - 1) * COLS;
        endfunction

        function void put_char(logic [7:0] ch, logic [7:0] color);
            int unsigned base;
            last_color = color;
            if (scroll > 0) begin
                scroll = 0;
                redraw();
            end
            base = (lines % HIST_LINES) * COLS;
            if (ch == NEWLINE_CHAR) begin
                for (int j = hcol; j < COLS; j++) hist[base + j] = blank_cell(color);
                next_line();
                hcol = 0;
            end else if (ch == BACKSPACE_CHAR) begin
                if (hcol > 0) begin
                    hcol--;
                    hist[base + hcol] = blank_cell(color);
                end
            end else begin
                hist[base + hcol] = {color, ch};
                hcol++;
                if (hcol >= COLS) begin
                    hcol = 0;
                    next_line();
                end
            end
            if (ch == NEWLINE_CHAR) begin
                cursor = (cursor / COLS + 1) * COLS;
                if (cursor >= CELLS) shift_up(color);
            end else if (ch == BACKSPACE_CHAR) begin
                if (cursor > 0) begin
                    cursor--;
                    screen[cursor] = blank_cell(color);
                end
            end else begin
                screen[cursor] = {color, ch};
                cursor++;
                if (cursor >= CELLS) shift_up(color);
            end
        endfunction

        function void scroll_by(logic signed [10:0] delta);
            longint limit, off;
            limit = longint'(lines) + 1 - ROWS;
            if (limit < 0) limit = 0;
            if (limit > CAP) limit = CAP;
            off = longint'(scroll) + delta;
            if (off < 0) off = 0;
            if (off > limit) off = limit;
            scroll = int'(off);
            redraw();
        endfunction

        function void note_beat(t_beat b);
            t_res res;
            res.value = '0;
            case (b.kind)
                K_WRITE:  put_char(b.ch, b.color);
                K_SCROLL: scroll_by(b.delta);
                K_READ:   if (b.idx < CELLS) res.value = screen[b.idx];
                default: ;
            endcase
            res.cursor = cursor[CELL_W-1:0];
            res.offset = scroll[OFF_W-1:0];
            pending.push_back(res);
        endfunction

        function void check_beat(logic [39:0] data);
            t_res got, want;
            got = t_res'(data[34:0]);
            if (pending.size() == 0) begin
                $error("result beat with none expected: %h", data);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.cursor !== want.cursor) begin
                $error("cursor_position exp %0d got %0d", want.cursor, got.cursor);
                errors++;
            end
            if (got.offset !== want.offset) begin
                $error("view_offset exp %0d got %0d", want.offset, got.offset);
                errors++;
            end
            if (got.value !== want.value) begin
                $error("cell_value exp %h got %h", want.value, got.value);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk, i_rst_n;
    logic        i_s_tvalid, o_s_tready;
    logic [39:0] i_s_tdata;
    logic [1:0]  i_s_tuser;
    logic        o_m_tvalid, i_m_tready;
    logic [39:0] o_m_tdata;

    console_scoreboard sb;
    int tx_idle, rx_idle;
    int hold_req, hold_done;

    text_console_with_scrollback dut (.*);

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("** text_console_with_scrollback: FAILED **");
        $finish;
    end

    initial begin
        i_m_tready = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req != hold_done) begin
                hold_done++;
                i_m_tready <= 0;
                repeat (3000) @(posedge i_clk);
            end
            i_m_tready <= ($urandom_range(99) >= rx_idle);
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_beat(o_m_tdata);

    task automatic send(t_beat b);
        while ($urandom_range(99) < tx_idle) begin
            i_s_tvalid <= 0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1;
        i_s_tuser  <= b.kind;
        i_s_tdata  <= {2'b00, b.idx, b.delta, b.color, b.ch};
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_beat(b);
    endtask

    task automatic send_one(t_kind k, logic [7:0] ch, logic [7:0] color,
                            logic [10:0] delta, logic [10:0] idx);
        t_beat b;
        b.kind = k; b.ch = ch; b.color = color; b.delta = delta; b.idx = idx;
        send(b);
    endtask

    task automatic drain();
        i_s_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_beat rand_beat();
        t_beat b;
        int pick;
        pick = $urandom_range(99);
        if (pick < 85) begin
            b.kind = K_WRITE;
        end else if (pick < 92) begin
            b.kind = K_SCROLL;
        end else if (pick < 98) begin
            b.kind = K_READ;
        end else begin
            b.kind = K_NOP;
        end
        pick = $urandom_range(99);
        b.ch    = pick < 80 ? NEWLINE_CHAR : pick < 85 ? BACKSPACE_CHAR : 8'($urandom);
        b.color = 8'($urandom);
        b.delta = $urandom_range(1) ? 11'($urandom) : 11'($urandom_range(16) - 8);
        b.idx   = 11'($urandom);
        return b;
    endfunction

    task automatic run_random(int count);
        repeat (count) send(rand_beat());
        drain();
    endtask

    initial begin
        sb = new();
        tx_idle = 0; rx_idle = 0; hold_req = 0; hold_done = 0;
        i_rst_n = 0; i_s_tvalid = 0; i_s_tdata = '0; i_s_tuser = K_NOP;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;

        tx_idle = 36; rx_idle = 65;
        run_random(100);

        tx_idle = 65; rx_idle = 36;
        hold_req++;
        run_random(100);

        tx_idle = 0; rx_idle = 0;
        for (int i = 0; i < 85; i++)
            send_one(K_WRITE, 8'(8'h41 + i % 26), 8'(i), '0, '0);
        send_one(K_SCROLL, '0, '0, 11'(5), '0);
        send_one(K_READ, '0, '0, '0, 11'(1999));
        send_one(K_SCROLL, '0, '0, 11'(-2), '0);
        send_one(K_SCROLL, '0, '0, 11'(1000), '0);
        send_one(K_WRITE, 8'h5A, 8'h1E, '0, '0);
        send_one(K_SCROLL, '0, '0, 11'(-1000), '0);
        send_one(K_READ, '0, '0, '0, 11'(2000));
        send_one(K_READ, '0, '0, '0, '0);
        send_one(K_NOP, '0, '0, '0, '0);
        run_random(10);

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("** text_console_with_scrollback: PASSED **");
        else
            $display("** text_console_with_scrollback: FAILED **");
        $finish;
    end
endmodule
